FILE: sv/xes_pkg.sv
`timescale 1ns / 1ps
// xes_pkg: item types, byte class constants and the command format passed
// from the front end to the back end of the XML escaper. No dependencies.
package xes_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } out_item_t;

    // body of a command
    typedef logic [2:0] body_kind_t;
    localparam body_kind_t BODY_NONE = 3'd0;
    localparam body_kind_t BODY_LIT  = 3'd1;   // 1 to 4 bytes copied as-is
    localparam body_kind_t BODY_LT   = 3'd2;
    localparam body_kind_t BODY_GT   = 3'd3;
    localparam body_kind_t BODY_AMP  = 3'd4;
    localparam body_kind_t BODY_QUOT = 3'd5;

    // one request through the queue: leading replacements, a body,
    // trailing replacements (string ended inside a sequence)
    typedef struct packed {
        logic [2:0]      pre_reps;
        body_kind_t      body;
        logic [2:0]      lit_len;
        logic [3:0][7:0] lit;
        logic [1:0]      post_reps;
        logic            last;
    } cmd_t;

    localparam logic [7:0] REPL_B0    = 8'hEF;
    localparam logic [7:0] REPL_B1    = 8'hBF;
    localparam logic [7:0] REPL_B2    = 8'hBD;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUOT    = 8'h22;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;

    localparam logic [31:0] ENT_LT   = "&lt;";
    localparam logic [31:0] ENT_GT   = "&gt;";
    localparam logic [39:0] ENT_AMP  = "&amp;";
    localparam logic [47:0] ENT_QUOT = "&quot;";

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] b;
        unique case (sub)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] body_len(input cmd_t c);
        logic [2:0] n;
        unique case (c.body)
            BODY_LIT:  n = c.lit_len;
            BODY_LT:   n = 3'd4;
            BODY_GT:   n = 3'd4;
            BODY_AMP:  n = 3'd5;
            BODY_QUOT: n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // entity text is stored first character in the top byte
    function automatic logic [7:0] body_byte(input cmd_t c, input logic [2:0] pos);
        logic [7:0] b;
        unique case (c.body)
            BODY_LIT:  b = c.lit[pos[1:0]];
            BODY_LT:   b = ENT_LT[{2'd3 - pos[1:0], 3'b000} +: 8];
            BODY_GT:   b = ENT_GT[{2'd3 - pos[1:0], 3'b000} +: 8];
            BODY_AMP:  b = ENT_AMP[{3'd4 - pos, 3'b000} +: 8];
            BODY_QUOT: b = ENT_QUOT[{3'd5 - pos, 3'b000} +: 8];
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/xes_front.sv
`timescale 1ns / 1ps
// xes_front: accepts raw bytes, tracks the open UTF-8 sequence and turns
// each byte into at most one queue request. Depends on xes_pkg.
module xes_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  xes_pkg::in_item_t item,
    output logic              push,
    output xes_pkg::cmd_t     cmd,
    output logic              seq_open
);
    import xes_pkg::*;

    logic [7:0] lead_reg, lead_next;
    logic [1:0] count_reg, count_next;
    logic [2:0] exp_reg, exp_next;
    logic [7:0] cont_reg [2];
    logic       cont_we;

    logic [7:0] b;
    logic       is_cont;
    logic       fresh;
    logic [2:0] pre;

    assign b        = item.in_byte;
    assign is_cont  = (b & CONT_MASK) == CONT_TAG;
    assign seq_open = exp_reg != 3'd0;

    always_comb
    begin
        cmd        = '0;
        fresh      = 1'b1;
        pre        = 3'd0;
        lead_next  = lead_reg;
        count_next = count_reg;
        exp_next   = exp_reg;
        cont_we    = 1'b0;

        if (exp_reg != 3'd0)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if ({1'b0, count_reg} + 3'd2 >= exp_reg)
                begin
                    // sequence complete: emit it whole
                    cmd.body    = BODY_LIT;
                    cmd.lit_len = {1'b0, count_reg} + 3'd2;
                    cmd.lit[0]  = lead_reg;
                    cmd.lit[1]  = (count_reg != 2'd0) ? cont_reg[0] : b;
                    cmd.lit[2]  = (count_reg == 2'd2) ? cont_reg[1] : b;
                    cmd.lit[3]  = b;
                    lead_next   = 8'h00;
                    count_next  = 2'd0;
                    exp_next    = 3'd0;
                end
                else
                begin
                    cont_we    = 1'b1;
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                // broken sequence: lead and each held byte are replaced
                pre        = {1'b0, count_reg} + 3'd1;
                lead_next  = 8'h00;
                count_next = 2'd0;
                exp_next   = 3'd0;
            end
        end

        if (fresh)
        begin
            if (b < CTRL_LIMIT && b != CH_TAB && b != CH_LF && b != CH_CR)
                pre = pre + 3'd1;
            else if (b == CH_LT)
                cmd.body = BODY_LT;
            else if (b == CH_GT)
                cmd.body = BODY_GT;
            else if (b == CH_AMP)
                cmd.body = BODY_AMP;
            else if (b == CH_QUOT)
                cmd.body = BODY_QUOT;
            else if (b < ASCII_LIMIT)
            begin
                cmd.body    = BODY_LIT;
                cmd.lit_len = 3'd1;
                cmd.lit[0]  = b;
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                exp_next   = 3'd2;
                lead_next  = b;
                count_next = 2'd0;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                exp_next   = 3'd3;
                lead_next  = b;
                count_next = 2'd0;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                exp_next   = 3'd4;
                lead_next  = b;
                count_next = 2'd0;
            end
            else
                pre = pre + 3'd1;
        end

        cmd.pre_reps = pre;
        cmd.last     = item.end_of_string;

        // string ends inside a sequence: flush what is held
        if (item.end_of_string && exp_next != 3'd0)
        begin
            cmd.post_reps = count_next + 2'd1;
            lead_next     = 8'h00;
            count_next    = 2'd0;
            exp_next      = 3'd0;
        end

        push = accept && (cmd.pre_reps != 3'd0 || cmd.body != BODY_NONE
                          || cmd.post_reps != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg  <= 8'h00;
            count_reg <= 2'd0;
            exp_reg   <= 3'd0;
        end
        else if (accept)
        begin
            lead_reg  <= lead_next;
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cont_we)
            cont_reg[count_reg[0]] <= b;
    end

endmodule

FILE: sv/xes_queue.sv
`timescale 1ns / 1ps
// xes_queue: small FIFO of requests between front and back end.
// Depends on xes_pkg.
module xes_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xes_pkg::cmd_t push_cmd,
    input  logic          pop,
    output xes_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import xes_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: sv/xes_back.sv
`timescale 1ns / 1ps
// xes_back: expands queued requests into output bytes, one per cycle while
// dst_stall is low, through a registered output stage. Depends on xes_pkg.
module xes_back (
    input  logic               clk,
    input  logic               rst_n,
    input  xes_pkg::cmd_t      head_cmd,
    input  logic               q_empty,
    output logic               pop,
    output logic               busy,
    output logic               dst_valid,
    input  logic               dst_stall,
    output xes_pkg::out_item_t dst_data
);
    import xes_pkg::*;

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_POST = 2'd2;

    cmd_t       cmd_reg;
    logic       busy_reg;
    logic [1:0] phase_reg;
    logic [2:0] cnt_reg;
    logic [1:0] sub_reg;
    logic [2:0] pos_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic [7:0] byte_c;
    logic       rep_end, seg_end, more, done, adv, load;
    logic [1:0] nxt_phase, first_phase;
    logic       has_body, has_post;

    assign has_body = cmd_reg.body != BODY_NONE;
    assign has_post = cmd_reg.post_reps != 2'd0;
    assign rep_end  = sub_reg == 2'd2;

    always_comb
    begin
        byte_c    = 8'h00;
        seg_end   = 1'b1;
        more      = 1'b0;
        nxt_phase = PH_POST;
        unique case (phase_reg)
            PH_PRE:
            begin
                byte_c    = repl_byte(sub_reg);
                seg_end   = rep_end && (cnt_reg + 3'd1 == cmd_reg.pre_reps);
                more      = has_body || has_post;
                nxt_phase = has_body ? PH_BODY : PH_POST;
            end
            PH_BODY:
            begin
                byte_c    = body_byte(cmd_reg, pos_reg);
                seg_end   = pos_reg + 3'd1 == body_len(cmd_reg);
                more      = has_post;
                nxt_phase = PH_POST;
            end
            PH_POST:
            begin
                byte_c  = repl_byte(sub_reg);
                seg_end = rep_end && (cnt_reg + 3'd1 == {1'b0, cmd_reg.post_reps});
            end
            default:
            begin
                byte_c  = 8'h00;
                seg_end = 1'b1;
            end
        endcase

        if (head_cmd.pre_reps != 3'd0)
            first_phase = PH_PRE;
        else if (head_cmd.body != BODY_NONE)
            first_phase = PH_BODY;
        else
            first_phase = PH_POST;
    end

    assign done      = seg_end && !more;
    assign adv       = busy_reg && (!out_valid_reg || !dst_stall);
    assign load      = (!busy_reg || (adv && done)) && !q_empty;
    assign pop       = load;
    assign busy      = busy_reg;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_PRE;
            cnt_reg       <= 3'd0;
            sub_reg       <= 2'd0;
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !dst_stall)
                out_valid_reg <= 1'b0;

            // a load while busy only happens on the last byte of a request
            if (load)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= first_phase;
                cnt_reg   <= 3'd0;
                sub_reg   <= 2'd0;
                pos_reg   <= 3'd0;
            end
            else if (adv)
            begin
                if (seg_end)
                begin
                    phase_reg <= nxt_phase;
                    cnt_reg   <= 3'd0;
                    sub_reg   <= 2'd0;
                    pos_reg   <= 3'd0;
                    if (done)
                        busy_reg <= 1'b0;
                end
                else if (phase_reg == PH_BODY)
                    pos_reg <= pos_reg + 3'd1;
                else if (rep_end)
                begin
                    sub_reg <= 2'd0;
                    cnt_reg <= cnt_reg + 3'd1;
                end
                else
                    sub_reg <= sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= head_cmd;
        if (adv)
        begin
            out_reg.out_byte <= byte_c;
            out_reg.last_out <= cmd_reg.last && done;
        end
    end

endmodule

FILE: sv/xml_escape_utf8_sanitizer.sv
`timescale 1ns / 1ps
// xml_escape_utf8_sanitizer: XML escaper with UTF-8 sanitizing.
// An accepted item passes a queue entry, the back end's request register and
// its output register. Input: 1 byte per cycle while the queue has room, also
// while earlier items expand. Output: 1 byte per cycle while dst_stall is low,
// set by the single byte lane of the back end; an item expands to 0..15 bytes.
// Reset (rst_n low, async): no sequence held, queue empty, no output valid.
// Depends on xes_pkg, xes_front, xes_queue, xes_back.
module xml_escape_utf8_sanitizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  xes_pkg::in_item_t  src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output xes_pkg::out_item_t dst_data
);
    import xes_pkg::*;

    // front -> queue
    logic  accept;
    logic  q_push;
    cmd_t  front_cmd;
    logic  seq_open;

    // queue -> back
    cmd_t  head_cmd;
    logic  q_full, q_empty, q_pop;
    logic  back_busy;

    // The front end only stalls when the queue is full; an item that
    // produces nothing (a held lead or continuation) is accepted without
    // a push.
    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;

    // Front: classify each byte, keep the open sequence, build a request
    // of leading replacements, a body (literal, entity or whole sequence)
    // and trailing replacements for a string that ends mid-sequence.
    xes_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (src_data),
        .push     (q_push),
        .cmd      (front_cmd),
        .seq_open (seq_open)
    );

    // Decouples the byte-rate input from the expanding output side.
    xes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: walks each request a byte at a time; the next request is
    // loaded on the same edge the last byte of the current one is
    // registered, so output runs without bubbles.
    xes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .busy      (back_busy),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // a request is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    // nothing stays held across a string boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src_data.end_of_string) |=> !seq_open)
        else $error("sequence still open after end of string");

    // output only becomes valid from an active request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(back_busy))
        else $error("output valid without an active request");

endmodule
